FILE: hw/rtl/rnbsp_pkg.sv
// ----------------------------------------------------------------------------
// rnbsp_pkg
// Shared types, constants and helpers of the nearest box / sphere ray picker.
// ----------------------------------------------------------------------------
`default_nettype none

package rnbsp_pkg;

   // table sizes
   localparam int BOX_ENTRIES_DEF    = 256;
   localparam int SPHERE_ENTRIES_DEF = 256;

   // configuration register limits and reset values
   localparam logic [16:0] CULL_RESET = 17'd10000;
   localparam logic [16:0] CULL_LOW   = 17'd100;
   localparam logic [16:0] CULL_HIGH  = 17'd100000;
   localparam logic [9:0]  PICK_RESET = 10'd30;
   localparam logic [9:0]  PICK_LOW   = 10'd1;
   localparam logic [9:0]  PICK_HIGH  = 10'd1000;

   // register index codes
   localparam logic CSR_CULL = 1'b0;
   localparam logic CSR_PICK = 1'b1;

   // hit kinds
   localparam logic KIND_BOX    = 1'b0;
   localparam logic KIND_SPHERE = 1'b1;

   // direction saturation range, Q2.16
   localparam logic signed [31:0] DIR_MAX = 32'sd131071;
   localparam logic signed [31:0] DIR_MIN = -32'sd131072;

   // sphere offsets at or beyond this magnitude are skipped
   localparam logic signed [32:0] FAR_LIMIT = 33'sd536870912;

   // serial unit lengths
   localparam int DIV_STEPS  = 49;
   localparam int SQRT_STEPS = 32;

   typedef enum logic [1:0] {
      FUNC_LOAD_BOX    = 2'd0,
      FUNC_LOAD_SPHERE = 2'd1,
      FUNC_QUERY       = 2'd2,
      FUNC_CLEAR       = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOX_RD,
      ST_BOX_AX,
      ST_BOX_WAIT,
      ST_BOX_END,
      ST_SPH_RD,
      ST_SPH_L,
      ST_SPH_MUL,
      ST_SPH_B,
      ST_SPH_R,
      ST_SPH_S,
      ST_SPH_CMP,
      ST_SPH_SQ,
      ST_SPH_END,
      ST_DONE
   } back_state_type;

   // one classified request
   typedef struct packed {
      func_type           func;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [17:0] d_x;
      logic signed [17:0] d_y;
      logic signed [17:0] d_z;
      logic [31:0]        id;
   } item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] entity;
      logic [30:0] distance;
      logic        kind;
   } result_type;

   typedef struct packed {
      logic [16:0] cull;
      logic [9:0]  pick;
   } csr_type;

   // saturate a direction component to Q2.16
   function automatic logic signed [17:0] sat_dir(input logic signed [31:0] v);
      logic signed [17:0] r;
      if (v > DIR_MAX) begin
         r = 18'sd131071;
      end else if (v < DIR_MIN) begin
         r = -18'sd131072;
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rnbsp_ram.sv
// ----------------------------------------------------------------------------
// rnbsp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rnbsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rnbsp_front.sv
// ----------------------------------------------------------------------------
// rnbsp_front
// Request intake: decodes the function, saturates the ray direction and
// holds requests in a two entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rnbsp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_point_a_x,
   input  wire logic signed [31:0] req_point_a_y,
   input  wire logic signed [31:0] req_point_a_z,
   input  wire logic signed [31:0] req_point_b_x,
   input  wire logic signed [31:0] req_point_b_y,
   input  wire logic signed [31:0] req_point_b_z,
   input  wire logic [31:0]        req_entity_id,
   output rnbsp_pkg::item_type     item,
   output logic                    item_valid,
   input  wire logic               item_pop
);

   rnbsp_pkg::item_type slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   rnbsp_pkg::item_type new_item;
   logic                push;

   // classify the incoming request
   always_comb begin
      new_item.func = rnbsp_pkg::func_type'(req_func);
      new_item.a_x  = req_point_a_x;
      new_item.a_y  = req_point_a_y;
      new_item.a_z  = req_point_a_z;
      new_item.b_x  = req_point_b_x;
      new_item.b_y  = req_point_b_y;
      new_item.b_z  = req_point_b_z;
      new_item.d_x  = rnbsp_pkg::sat_dir(req_point_b_x);
      new_item.d_y  = rnbsp_pkg::sat_dir(req_point_b_y);
      new_item.d_z  = rnbsp_pkg::sat_dir(req_point_b_z);
      new_item.id   = req_entity_id;
   end

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rnbsp_div.sv
// ----------------------------------------------------------------------------
// rnbsp_div
// Serial signed divider for slab times: (num * 65536) / den, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rnbsp_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [32:0] num,
   input  wire logic signed [17:0] den,
   output logic                    done,
   output logic signed [49:0]      quo
);

   logic [48:0] dvd_ff, dvd_in;
   logic [17:0] rem_ff, rem_in;
   logic [17:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [32:0] num_mag;
   logic [18:0] rem_sh;
   logic        fit;

   assign num_mag = num[32] ? 33'(-num) : 33'(num);
   assign rem_sh  = {rem_ff, dvd_ff[48]};
   assign fit     = (rem_sh >= {1'b0, den_ff});

   // one restoring step a cycle
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = {num_mag, 16'b0};
         rem_in = 18'd0;
         den_in = den[17] ? 18'(-den) : 18'(den);
         neg_in = num[32] ^ den[17];
         cnt_in = 6'(rnbsp_pkg::DIV_STEPS);
      end else if (cnt_ff != 6'd0) begin
         rem_in  = fit ? 18'(rem_sh - {1'b0, den_ff}) : rem_sh[17:0];
         dvd_in  = {dvd_ff[47:0], fit};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});

endmodule

`default_nettype wire

FILE: hw/rtl/rnbsp_sqrt.sv
// ----------------------------------------------------------------------------
// rnbsp_sqrt
// Serial integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rnbsp_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] x,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // digit by digit step
   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = x;
         res_in = 64'd0;
         bit_in = 64'd1 << 62;
         cnt_in = 6'(rnbsp_pkg::SQRT_STEPS);
      end else if (cnt_ff != 6'd0) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

FILE: hw/rtl/rnbsp_back.sv
// ----------------------------------------------------------------------------
// rnbsp_back
// Execution back end: table loads and clears, and the query walk over the
// box table (slab test) and the sphere table, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rnbsp_back #(
   parameter int BOX_ENTRIES    = rnbsp_pkg::BOX_ENTRIES_DEF,
   parameter int SPHERE_ENTRIES = rnbsp_pkg::SPHERE_ENTRIES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rnbsp_pkg::item_type  item,
   input  wire logic                 item_valid,
   output logic                      item_pop,
   input  wire rnbsp_pkg::csr_type   csr,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rnbsp_pkg::result_type     rsp
);

   localparam int BCW = $clog2(BOX_ENTRIES + 1);
   localparam int SCW = $clog2(SPHERE_ENTRIES + 1);
   localparam int BAW = (BOX_ENTRIES > 1) ? $clog2(BOX_ENTRIES) : 1;
   localparam int SAW = (SPHERE_ENTRIES > 1) ? $clog2(SPHERE_ENTRIES) : 1;
   localparam int IW  = (BCW > SCW) ? BCW : SCW;

   localparam logic signed [49:0] TMAX_INIT = {1'b0, {49{1'b1}}};

   typedef struct packed {
      logic [IW-1:0]      idx;
      logic [1:0]         axis;
      logic               phase;
      logic               miss;
      logic [2:0][31:0]   org;
      logic [2:0][17:0]   dir;
      logic signed [49:0] tmin;
      logic signed [49:0] tmax;
      logic signed [49:0] t1;
      logic               have_box;
      logic [30:0]        best_box;
      logic [31:0]        box_id;
      logic               have_sph;
      logic [30:0]        best_sph;
      logic [31:0]        sph_id;
      logic [2:0][32:0]   l;
      logic [63:0]        ll;
      logic [63:0]        sum;
      logic signed [49:0] b24;
      logic [2:0]         step;
   } dp_type;

   typedef struct packed {
      logic pop;
      logic box_we;
      logic sph_we;
      logic div_start;
      logic sqrt_start;
      logic rsp_load;
   } ctrl_type;

   rnbsp_pkg::back_state_type state_ff, state_in;
   dp_type                    dp_ff, dp_in;
   logic [BCW-1:0]            box_cnt_ff, box_cnt_in;
   logic [SCW-1:0]            sph_cnt_ff, sph_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rnbsp_pkg::result_type     rsp_ff, rsp_in;
   logic signed [67:0]        prod_ff;
   ctrl_type                  ctrl;

   logic [223:0]              box_rd;
   logic [127:0]              sph_rd;
   logic [2:0][31:0]          box_lo, box_hi, sph_c;
   logic                      box_free, sph_free, out_free;

   logic signed [31:0]        org_sel, lo_sel, hi_sel;
   logic signed [17:0]        dir_sel;
   logic signed [32:0]        div_num;
   logic                      div_done, sqrt_done;
   logic signed [49:0]        quo;
   logic [31:0]               root;
   logic                      zero_out;
   logic signed [49:0]        t_lo, t_hi;
   logic signed [49:0]        limit50;
   logic signed [34:0]        limit35;
   logic [2:0][32:0]          l_new;
   logic                      far;
   logic signed [33:0]        mul_a, mul_b;
   logic signed [33:0]        b8, bmag;
   logic signed [34:0]        near;
   logic [IW-1:0]             idx_next;
   logic                      box_last, sph_last;
   logic                      box_hit, sph_hit, sum_short;
   logic [31:0]               bias_sum;
   logic                      box_wins;

   // table memories
   rnbsp_ram #(.WIDTH(224), .DEPTH(BOX_ENTRIES)) u_box_ram (
      .clock   (clock),
      .wr_en   (ctrl.box_we),
      .wr_addr (box_cnt_ff[BAW-1:0]),
      .wr_data ({item.id, item.b_z, item.b_y, item.b_x, item.a_z, item.a_y, item.a_x}),
      .rd_addr (dp_ff.idx[BAW-1:0]),
      .rd_data (box_rd)
   );

   rnbsp_ram #(.WIDTH(128), .DEPTH(SPHERE_ENTRIES)) u_sph_ram (
      .clock   (clock),
      .wr_en   (ctrl.sph_we),
      .wr_addr (sph_cnt_ff[SAW-1:0]),
      .wr_data ({item.id, item.a_z, item.a_y, item.a_x}),
      .rd_addr (dp_ff.idx[SAW-1:0]),
      .rd_data (sph_rd)
   );

   // shared serial units
   rnbsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (div_num),
      .den   (dir_sel),
      .done  (div_done),
      .quo   (quo)
   );

   rnbsp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (ctrl.sqrt_start),
      .x     (dp_ff.sum - dp_ff.ll),
      .done  (sqrt_done),
      .root  (root)
   );

   // entry fields
   assign box_lo = box_rd[95:0];
   assign box_hi = box_rd[191:96];
   assign sph_c  = sph_rd[95:0];

   assign box_free = (box_cnt_ff < BCW'(BOX_ENTRIES));
   assign sph_free = (sph_cnt_ff < SCW'(SPHERE_ENTRIES));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slab test datapath
   assign org_sel  = $signed(dp_ff.org[dp_ff.axis]);
   assign dir_sel  = $signed(dp_ff.dir[dp_ff.axis]);
   assign lo_sel   = $signed(box_lo[dp_ff.axis]);
   assign hi_sel   = $signed(box_hi[dp_ff.axis]);
   assign div_num  = (dp_ff.phase ? {hi_sel[31], hi_sel} : {lo_sel[31], lo_sel})
                     - {org_sel[31], org_sel};
   assign zero_out = (org_sel < lo_sel) || (org_sel > hi_sel);
   assign t_lo     = (dp_ff.t1 < quo) ? dp_ff.t1 : quo;
   assign t_hi     = (dp_ff.t1 < quo) ? quo : dp_ff.t1;
   assign limit50  = $signed({25'b0, csr.cull, 8'b0});
   assign limit35  = $signed({10'b0, csr.cull, 8'b0});

   // sphere offsets and far check
   always_comb begin
      far = 1'b0;
      for (int k = 0; k < 3; k++) begin
         l_new[k] = {sph_c[k][31], sph_c[k]} - {dp_ff.org[k][31], dp_ff.org[k]};
         if (($signed(l_new[k]) >= rnbsp_pkg::FAR_LIMIT) ||
             ($signed(l_new[k]) <= -rnbsp_pkg::FAR_LIMIT)) begin
            far = 1'b1;
         end
      end
   end

   assign b8   = dp_ff.b24[49:16];
   assign bmag = b8[33] ? -b8 : b8;
   assign near = {b8[33], b8} - $signed({3'b0, root});

   // shared multiplier operands
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      case (state_ff)
         rnbsp_pkg::ST_SPH_MUL: begin
            if (dp_ff.step < 3'd3) begin
               mul_a = $signed({dp_ff.l[dp_ff.step[1:0]][32], dp_ff.l[dp_ff.step[1:0]]});
               mul_b = mul_a;
            end else if (dp_ff.step < 3'd6) begin
               mul_a = $signed({dp_ff.l[2'(dp_ff.step - 3'd3)][32],
                                dp_ff.l[2'(dp_ff.step - 3'd3)]});
               mul_b = 34'($signed(dp_ff.dir[2'(dp_ff.step - 3'd3)]));
            end
         end
         rnbsp_pkg::ST_SPH_B: begin
            mul_a = bmag;
            mul_b = bmag;
         end
         rnbsp_pkg::ST_SPH_R: begin
            mul_a = $signed({16'b0, csr.pick, 8'b0});
            mul_b = mul_a;
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   // walk bookkeeping
   assign idx_next  = dp_ff.idx + 1'b1;
   assign box_last  = (idx_next == IW'(box_cnt_ff));
   assign sph_last  = (idx_next == IW'(sph_cnt_ff));
   assign sum_short = (dp_ff.sum < dp_ff.ll);
   assign box_hit   = !dp_ff.miss && (dp_ff.tmin <= dp_ff.tmax) && (dp_ff.tmin <= limit50)
                      && (!dp_ff.have_box || (dp_ff.tmin < $signed({19'b0, dp_ff.best_box})));
   assign sph_hit   = !dp_ff.miss && (near >= 35'sd0) && (near <= limit35)
                      && (!dp_ff.have_sph || (near < $signed({4'b0, dp_ff.best_sph})));
   assign bias_sum  = {1'b0, dp_ff.best_sph} + {14'b0, csr.pick, 8'b0};
   assign box_wins  = dp_ff.have_box && (!dp_ff.have_sph || ({1'b0, dp_ff.best_box} <= bias_sum));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rnbsp_pkg::ST_IDLE: begin
            if (item_valid && (item.func == rnbsp_pkg::FUNC_QUERY)) begin
               if (box_cnt_ff != BCW'(0)) begin
                  state_in = rnbsp_pkg::ST_BOX_RD;
               end else if (sph_cnt_ff != SCW'(0)) begin
                  state_in = rnbsp_pkg::ST_SPH_RD;
               end else begin
                  state_in = rnbsp_pkg::ST_DONE;
               end
            end
         end
         rnbsp_pkg::ST_BOX_RD:   state_in = rnbsp_pkg::ST_BOX_AX;
         rnbsp_pkg::ST_BOX_AX: begin
            if (dir_sel != 18'sd0) begin
               state_in = rnbsp_pkg::ST_BOX_WAIT;
            end else if (dp_ff.axis == 2'd2) begin
               state_in = rnbsp_pkg::ST_BOX_END;
            end
         end
         rnbsp_pkg::ST_BOX_WAIT: begin
            if (div_done) begin
               state_in = (dp_ff.phase && (dp_ff.axis == 2'd2)) ? rnbsp_pkg::ST_BOX_END
                                                                : rnbsp_pkg::ST_BOX_AX;
            end
         end
         rnbsp_pkg::ST_BOX_END: begin
            if (!box_last) begin
               state_in = rnbsp_pkg::ST_BOX_RD;
            end else if (sph_cnt_ff != SCW'(0)) begin
               state_in = rnbsp_pkg::ST_SPH_RD;
            end else begin
               state_in = rnbsp_pkg::ST_DONE;
            end
         end
         rnbsp_pkg::ST_SPH_RD:   state_in = rnbsp_pkg::ST_SPH_L;
         rnbsp_pkg::ST_SPH_L:    state_in = far ? rnbsp_pkg::ST_SPH_END : rnbsp_pkg::ST_SPH_MUL;
         rnbsp_pkg::ST_SPH_MUL:  state_in = (dp_ff.step == 3'd6) ? rnbsp_pkg::ST_SPH_B
                                                                 : rnbsp_pkg::ST_SPH_MUL;
         rnbsp_pkg::ST_SPH_B:    state_in = rnbsp_pkg::ST_SPH_R;
         rnbsp_pkg::ST_SPH_R:    state_in = rnbsp_pkg::ST_SPH_S;
         rnbsp_pkg::ST_SPH_S:    state_in = rnbsp_pkg::ST_SPH_CMP;
         rnbsp_pkg::ST_SPH_CMP:  state_in = sum_short ? rnbsp_pkg::ST_SPH_END
                                                      : rnbsp_pkg::ST_SPH_SQ;
         rnbsp_pkg::ST_SPH_SQ:   state_in = sqrt_done ? rnbsp_pkg::ST_SPH_END
                                                      : rnbsp_pkg::ST_SPH_SQ;
         rnbsp_pkg::ST_SPH_END:  state_in = sph_last ? rnbsp_pkg::ST_DONE : rnbsp_pkg::ST_SPH_RD;
         rnbsp_pkg::ST_DONE:     state_in = out_free ? rnbsp_pkg::ST_IDLE : rnbsp_pkg::ST_DONE;
         default:                state_in = rnbsp_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         rnbsp_pkg::ST_IDLE: begin
            ctrl.pop    = item_valid;
            ctrl.box_we = item_valid && (item.func == rnbsp_pkg::FUNC_LOAD_BOX) && box_free;
            ctrl.sph_we = item_valid && (item.func == rnbsp_pkg::FUNC_LOAD_SPHERE) && sph_free;
         end
         rnbsp_pkg::ST_BOX_AX:  ctrl.div_start  = (dir_sel != 18'sd0);
         rnbsp_pkg::ST_SPH_CMP: ctrl.sqrt_start = !sum_short;
         rnbsp_pkg::ST_DONE:    ctrl.rsp_load   = out_free;
         default:               ctrl = '0;
      endcase
   end

   assign item_pop = ctrl.pop;

   // table counts
   always_comb begin
      box_cnt_in = box_cnt_ff;
      sph_cnt_in = sph_cnt_ff;
      if (ctrl.box_we) begin
         box_cnt_in = box_cnt_ff + 1'b1;
      end
      if (ctrl.sph_we) begin
         sph_cnt_in = sph_cnt_ff + 1'b1;
      end
      if ((state_ff == rnbsp_pkg::ST_IDLE) && item_valid &&
          (item.func == rnbsp_pkg::FUNC_CLEAR)) begin
         box_cnt_in = BCW'(0);
         sph_cnt_in = SCW'(0);
      end
   end

   // query datapath
   always_comb begin
      dp_in = dp_ff;
      case (state_ff)
         rnbsp_pkg::ST_IDLE: begin
            dp_in.idx      = IW'(0);
            dp_in.org      = {item.a_z, item.a_y, item.a_x};
            dp_in.dir      = {item.d_z, item.d_y, item.d_x};
            dp_in.have_box = 1'b0;
            dp_in.have_sph = 1'b0;
            dp_in.best_box = 31'd0;
            dp_in.best_sph = 31'd0;
            dp_in.box_id   = 32'd0;
            dp_in.sph_id   = 32'd0;
         end
         rnbsp_pkg::ST_BOX_RD: begin
            dp_in.axis  = 2'd0;
            dp_in.phase = 1'b0;
            dp_in.miss  = 1'b0;
            dp_in.tmin  = 50'sd0;
            dp_in.tmax  = TMAX_INIT;
         end
         rnbsp_pkg::ST_BOX_AX: begin
            if (dir_sel == 18'sd0) begin
               if (zero_out) begin
                  dp_in.miss = 1'b1;
               end
               if (dp_ff.axis != 2'd2) begin
                  dp_in.axis = dp_ff.axis + 2'd1;
               end
            end
         end
         rnbsp_pkg::ST_BOX_WAIT: begin
            if (div_done) begin
               if (!dp_ff.phase) begin
                  dp_in.t1    = quo;
                  dp_in.phase = 1'b1;
               end else begin
                  dp_in.tmin  = (t_lo > dp_ff.tmin) ? t_lo : dp_ff.tmin;
                  dp_in.tmax  = (t_hi < dp_ff.tmax) ? t_hi : dp_ff.tmax;
                  dp_in.phase = 1'b0;
                  if (dp_ff.axis != 2'd2) begin
                     dp_in.axis = dp_ff.axis + 2'd1;
                  end
               end
            end
         end
         rnbsp_pkg::ST_BOX_END: begin
            if (box_hit) begin
               dp_in.have_box = 1'b1;
               dp_in.best_box = dp_ff.tmin[30:0];
               dp_in.box_id   = box_rd[223:192];
            end
            dp_in.idx = box_last ? IW'(0) : idx_next;
         end
         rnbsp_pkg::ST_SPH_L: begin
            dp_in.l    = l_new;
            dp_in.miss = far;
            dp_in.ll   = 64'd0;
            dp_in.b24  = 50'sd0;
            dp_in.step = 3'd0;
         end
         rnbsp_pkg::ST_SPH_MUL: begin
            if (dp_ff.step != 3'd0) begin
               if (dp_ff.step <= 3'd3) begin
                  dp_in.ll = dp_ff.ll + prod_ff[63:0];
               end else begin
                  dp_in.b24 = dp_ff.b24 + prod_ff[49:0];
               end
            end
            dp_in.step = dp_ff.step + 3'd1;
         end
         rnbsp_pkg::ST_SPH_R:   dp_in.sum = prod_ff[63:0];
         rnbsp_pkg::ST_SPH_S:   dp_in.sum = dp_ff.sum + prod_ff[63:0];
         rnbsp_pkg::ST_SPH_CMP: begin
            if (sum_short) begin
               dp_in.miss = 1'b1;
            end
         end
         rnbsp_pkg::ST_SPH_END: begin
            if (sph_hit) begin
               dp_in.have_sph = 1'b1;
               dp_in.best_sph = near[30:0];
               dp_in.sph_id   = sph_rd[127:96];
            end
            dp_in.idx = idx_next;
         end
         default: dp_in = dp_ff;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
         if (box_wins) begin
            rsp_in.found    = 1'b1;
            rsp_in.entity   = dp_ff.box_id;
            rsp_in.distance = dp_ff.best_box;
            rsp_in.kind     = rnbsp_pkg::KIND_BOX;
         end else if (dp_ff.have_sph) begin
            rsp_in.found    = 1'b1;
            rsp_in.entity   = dp_ff.sph_id;
            rsp_in.distance = dp_ff.best_sph;
            rsp_in.kind     = rnbsp_pkg::KIND_SPHERE;
         end else begin
            rsp_in.found    = 1'b0;
            rsp_in.entity   = 32'd0;
            rsp_in.distance = 31'd0;
            rsp_in.kind     = rnbsp_pkg::KIND_BOX;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnbsp_pkg::ST_IDLE;
         box_cnt_ff   <= BCW'(0);
         sph_cnt_ff   <= SCW'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_cnt_ff   <= box_cnt_in;
         sph_cnt_ff   <= sph_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dp_ff   <= dp_in;
      rsp_ff  <= rsp_in;
      prod_ff <= mul_a * mul_b;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ray_nearest_box_sphere_pick_top.sv
// ----------------------------------------------------------------------------
// ray_nearest_box_sphere_pick_top
// Nearest box / sphere marker ray picker with an APB-style register port.
// ----------------------------------------------------------------------------
// Box loads, sphere loads and clears are taken from the queue one a cycle
// while no query is running. A query walks every stored box and then every
// stored sphere. Per box, an axis with a nonzero direction takes two divides
// on the serial slab divider (one quotient bit a cycle), an axis with a zero
// direction takes none. A sphere marker skipped as too far, or one that the
// ray misses before the square root, does not use the serial square root.
// The divider dominates the box walk and the serial square root the sphere
// walk. A two entry request queue lets requests keep arriving while a query
// runs, and the result register lets the next request start before the
// result is taken. Configuration is to be written only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module ray_nearest_box_sphere_pick_top #(
   parameter int BOX_ENTRIES    = rnbsp_pkg::BOX_ENTRIES_DEF,
   parameter int SPHERE_ENTRIES = rnbsp_pkg::SPHERE_ENTRIES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_point_a_x,
   input  wire logic signed [31:0] req_point_a_y,
   input  wire logic signed [31:0] req_point_a_z,
   input  wire logic signed [31:0] req_point_b_x,
   input  wire logic signed [31:0] req_point_b_y,
   input  wire logic signed [31:0] req_point_b_z,
   input  wire logic [31:0]        req_entity_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit_found,
   output logic [31:0]             rsp_hit_entity,
   output logic [30:0]             rsp_hit_distance,
   output logic                    rsp_hit_kind,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   rnbsp_pkg::csr_type    csr_ff, csr_in;
   rnbsp_pkg::item_type   item;
   logic                  item_valid, item_pop;
   rnbsp_pkg::result_type rsp;
   logic                  wr_en;
   logic [16:0]           cull_raw;
   logic [9:0]            pick_raw;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite && pready;
   assign cull_raw = pwdata[16:0];
   assign pick_raw = pwdata[9:0];

   // register writes with clamping
   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         case (paddr[2])
            rnbsp_pkg::CSR_CULL: begin
               if (cull_raw < rnbsp_pkg::CULL_LOW) begin
                  csr_in.cull = rnbsp_pkg::CULL_LOW;
               end else if (cull_raw > rnbsp_pkg::CULL_HIGH) begin
                  csr_in.cull = rnbsp_pkg::CULL_HIGH;
               end else begin
                  csr_in.cull = cull_raw;
               end
            end
            rnbsp_pkg::CSR_PICK: begin
               if (pick_raw < rnbsp_pkg::PICK_LOW) begin
                  csr_in.pick = rnbsp_pkg::PICK_LOW;
               end else if (pick_raw > rnbsp_pkg::PICK_HIGH) begin
                  csr_in.pick = rnbsp_pkg::PICK_HIGH;
               end else begin
                  csr_in.pick = pick_raw;
               end
            end
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.cull <= rnbsp_pkg::CULL_RESET;
         csr_ff.pick <= rnbsp_pkg::PICK_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // register reads
   always_comb begin
      case (paddr[2])
         rnbsp_pkg::CSR_CULL: prdata = {15'b0, csr_ff.cull};
         rnbsp_pkg::CSR_PICK: prdata = {22'b0, csr_ff.pick};
         default:             prdata = 32'd0;
      endcase
   end

   rnbsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_point_a_x (req_point_a_x),
      .req_point_a_y (req_point_a_y),
      .req_point_a_z (req_point_a_z),
      .req_point_b_x (req_point_b_x),
      .req_point_b_y (req_point_b_y),
      .req_point_b_z (req_point_b_z),
      .req_entity_id (req_entity_id),
      .item          (item),
      .item_valid    (item_valid),
      .item_pop      (item_pop)
   );

   rnbsp_back #(
      .BOX_ENTRIES    (BOX_ENTRIES),
      .SPHERE_ENTRIES (SPHERE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .csr        (csr_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_hit_found    = rsp.found;
   assign rsp_hit_entity   = rsp.entity;
   assign rsp_hit_distance = rsp.distance;
   assign rsp_hit_kind     = rsp.kind;

endmodule

`default_nettype wire
